// ===== hdl/best_rational_approximation_macros.svh =====
// assertion macros for the best rational approximation block
`ifndef BEST_RATIONAL_APPROXIMATION_MACROS_SVH
`define BEST_RATIONAL_APPROXIMATION_MACROS_SVH
`ifndef SYNTHESIS
`define BRA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BRA_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define BRA_ASSERT(lbl, prop, msg)
`define BRA_NEVER(lbl, cond, msg)
`endif
`endif

// ===== hdl/bra_pkg.sv =====
// shared constants for the best rational approximation block
package bra_pkg;
    localparam int NUM_W = 48;
    localparam int DEN_W = 31;
    localparam int A_W = 31;
    localparam logic [DEN_W-1:0] DEN_RESET = 31'd1000;
    localparam logic [A_W-1:0] QUOT_LIMIT = 31'h7FFFFFFF;
    localparam logic [NUM_W-1:0] NUM_MAX = {NUM_W{1'b1}};
endpackage

// ===== hdl/best_rational_approximation.sv =====
// Best rational approximation: continued fraction with bit-serial divide and multiply-add.
// One item at a time: in_ready is high only while no item is in work or output.
// Results come out as two transfers, the convergent and then the semiconvergent.
// Reset clears control and sets the denominator limit to 1000.
`include "best_rational_approximation_macros.svh"
module best_rational_approximation #(
    parameter int FRAC_BITS = 32,
    parameter int INT_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        max_denominator_wr,
    input  logic [bra_pkg::DEN_W-1:0]   max_denominator,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [bra_pkg::NUM_W-1:0]   value,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [bra_pkg::NUM_W-1:0]   numerator,
    output logic [bra_pkg::DEN_W-1:0]   denominator,
    output logic                        last
);
    localparam int W = INT_BITS + FRAC_BITS;
    localparam int QW = FRAC_BITS + 1;
    localparam int AW = bra_pkg::A_W;
    localparam int KW = bra_pkg::DEN_W;
    localparam int NW = bra_pkg::NUM_W;
    localparam int DW = (W > AW) ? W : AW;
    localparam int VW = (QW > AW) ? QW : AW;
    localparam int CW = $clog2(DW + 1);
    localparam int VALW = (W > NW) ? W : NW;
    localparam int HW = ((INT_BITS + 32 > NW) ? INT_BITS + 32 : NW) + 1;

    typedef enum logic [2:0] {
        S_IDLE, S_DIV, S_MUL, S_FIN, S_FDIV, S_FMUL, S_OUT0, S_OUT1
    } state_t;

    state_t          state_reg;
    logic [KW-1:0]   cfg_reg;
    logic [KW-1:0]   lim_reg;
    logic [QW-1:0]   q_reg;
    logic [QW-1:0]   r_reg;
    logic [AW-1:0]   a_reg;
    logic [HW-1:0]   h0_reg;
    logic [HW-1:0]   h1_reg;
    logic [KW-1:0]   k0_reg;
    logic [KW-1:0]   k1_reg;
    logic            div_start_reg;
    logic [DW-1:0]   div_dvd_reg;
    logic [VW-1:0]   div_dvs_reg;
    logic [CW-1:0]   div_cnt_reg;
    logic            mul_start_reg;
    logic            out_valid_reg;
    logic [NW-1:0]   num_reg;
    logic [KW-1:0]   den_reg;
    logic            last_reg;
    logic [NW-1:0]   semi_num_reg;
    logic [KW-1:0]   semi_den_reg;

    logic            div_done;
    logic [DW-1:0]   div_quot;
    logic [VW-1:0]   div_rem;
    logic            mul_done;
    logic [HW-1:0]   mul_h;
    logic            mul_hs;
    logic [KW-1:0]   mul_k;
    logic            mul_ks;
    logic [VALW-1:0] value_ext;
    logic [QW-1:0]   q_init;
    logic            quot_huge;
    logic [NW-1:0]   conv_num;
    logic [NW-1:0]   semi_num;

    // serial divider shared by the expansion and the final quotient
    bra_div #(.DW(DW), .VW(VW), .CW(CW)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start_reg),
        .dividend  (div_dvd_reg),
        .divisor   (div_dvs_reg),
        .steps     (div_cnt_reg),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    // serial multiply-add for both matrix rows
    bra_muladd #(.HW(HW)) u_muladd (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start_reg),
        .a     (a_reg),
        .mh    (h0_reg),
        .ah    (h1_reg),
        .mk    (k0_reg),
        .ak    (k1_reg),
        .done  (mul_done),
        .h_res (mul_h),
        .h_sat (mul_hs),
        .k_res (mul_k),
        .k_sat (mul_ks)
    );

    // operand shaping, stop test and numerator saturation
    always_comb
    begin
        value_ext = VALW'(value);
        q_init    = {1'b1, {FRAC_BITS{1'b0}}};
        quot_huge = (div_quot > DW'(bra_pkg::QUOT_LIMIT))
                 || ((div_quot == DW'(bra_pkg::QUOT_LIMIT)) && (div_rem != '0));
        conv_num  = (|h0_reg[HW-1:NW]) ? bra_pkg::NUM_MAX : h0_reg[NW-1:0];
        semi_num  = (mul_hs || (|mul_h[HW-1:NW])) ? bra_pkg::NUM_MAX : mul_h[NW-1:0];
    end

    // sequencer with registered result port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cfg_reg       <= bra_pkg::DEN_RESET;
            lim_reg       <= bra_pkg::DEN_RESET;
            q_reg         <= '0;
            r_reg         <= '0;
            a_reg         <= '0;
            h0_reg        <= '0;
            h1_reg        <= '0;
            k0_reg        <= '0;
            k1_reg        <= '0;
            div_start_reg <= 1'b0;
            div_dvd_reg   <= '0;
            div_dvs_reg   <= '0;
            div_cnt_reg   <= '0;
            mul_start_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            num_reg       <= '0;
            den_reg       <= '0;
            last_reg      <= 1'b0;
            semi_num_reg  <= '0;
            semi_den_reg  <= '0;
        end
        else
        begin
            div_start_reg <= 1'b0;
            mul_start_reg <= 1'b0;
            if (max_denominator_wr)
            begin
                cfg_reg <= max_denominator;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        lim_reg       <= (cfg_reg == '0) ? KW'(1) : cfg_reg;
                        q_reg         <= q_init;
                        h0_reg        <= HW'(1);
                        h1_reg        <= '0;
                        k0_reg        <= '0;
                        k1_reg        <= KW'(1);
                        div_dvd_reg   <= DW'(value_ext[W-1:0]) << (DW - W);
                        div_dvs_reg   <= VW'(q_init);
                        div_cnt_reg   <= CW'(W);
                        div_start_reg <= 1'b1;
                        state_reg     <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        if (quot_huge)
                        begin
                            state_reg <= S_FIN;
                        end
                        else
                        begin
                            a_reg         <= div_quot[AW-1:0];
                            r_reg         <= div_rem[QW-1:0];
                            mul_start_reg <= 1'b1;
                            state_reg     <= S_MUL;
                        end
                    end
                end
                S_MUL:
                begin
                    if (mul_done)
                    begin
                        if (mul_ks || (mul_k > lim_reg))
                        begin
                            state_reg <= S_FIN;
                        end
                        else
                        begin
                            h1_reg <= h0_reg;
                            h0_reg <= mul_h;
                            k1_reg <= k0_reg;
                            k0_reg <= mul_k;
                            if (r_reg == '0)
                            begin
                                state_reg <= S_FIN;
                            end
                            else
                            begin
                                q_reg         <= r_reg;
                                div_dvd_reg   <= DW'(q_reg) << (DW - QW);
                                div_dvs_reg   <= VW'(r_reg);
                                div_cnt_reg   <= CW'(QW);
                                div_start_reg <= 1'b1;
                                state_reg     <= S_DIV;
                            end
                        end
                    end
                end
                S_FIN:
                begin
                    div_dvd_reg   <= DW'(lim_reg - k1_reg) << (DW - AW);
                    div_dvs_reg   <= VW'(k0_reg);
                    div_cnt_reg   <= CW'(AW);
                    div_start_reg <= 1'b1;
                    state_reg     <= S_FDIV;
                end
                S_FDIV:
                begin
                    if (div_done)
                    begin
                        a_reg         <= div_quot[AW-1:0];
                        mul_start_reg <= 1'b1;
                        state_reg     <= S_FMUL;
                    end
                end
                S_FMUL:
                begin
                    if (mul_done)
                    begin
                        num_reg       <= conv_num;
                        den_reg       <= k0_reg;
                        last_reg      <= 1'b0;
                        semi_num_reg  <= semi_num;
                        semi_den_reg  <= mul_k;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_OUT0;
                    end
                end
                S_OUT0:
                begin
                    if (out_ready)
                    begin
                        num_reg   <= semi_num_reg;
                        den_reg   <= semi_den_reg;
                        last_reg  <= 1'b1;
                        state_reg <= S_OUT1;
                    end
                end
                S_OUT1:
                begin
                    if (out_ready)
                    begin
                        out_valid_reg <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_ready    = (state_reg == S_IDLE);
    assign out_valid   = out_valid_reg;
    assign numerator   = num_reg;
    assign denominator = den_reg;
    assign last        = last_reg;

    // checks on the sequencer
    `BRA_ASSERT(a_den_range, out_valid |-> (denominator != '0) && (denominator <= lim_reg), "denominator out of range")
    `BRA_ASSERT(a_ready_idle, in_ready |-> !out_valid, "input taken while a result waits")
    `BRA_ASSERT(a_last_ends, (out_valid && out_ready && last) |=> !out_valid, "result after the last transfer")
    `BRA_ASSERT(a_fin_order, (state_reg == S_FIN) |-> (k0_reg != '0) && (k1_reg <= lim_reg), "bad convergent at finish")
    `BRA_NEVER(a_no_overlap, div_start_reg && mul_start_reg, "divider and multiplier started together")
endmodule

// ===== hdl/bra_div.sv =====
// bit-serial restoring divider, one quotient bit per cycle
module bra_div #(
    parameter int DW = 48,
    parameter int VW = 33,
    parameter int CW = 6
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    input  logic [CW-1:0] steps,
    output logic          done,
    output logic [DW-1:0] quotient,
    output logic [VW-1:0] remainder
);
    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [DW-1:0] dq_reg;
    logic [VW-1:0] rem_reg;
    logic [VW-1:0] dvs_reg;
    logic [VW:0]   trial;
    logic          fits;

    // trial subtraction of the divisor from the shifted remainder
    always_comb
    begin
        trial = {rem_reg, dq_reg[DW-1]};
        fits  = (trial >= {1'b0, dvs_reg});
    end

    // step control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= steps;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // dividend shifts out at the top, quotient bits shift in at the bottom
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dq_reg  <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            dq_reg  <= {dq_reg[DW-2:0], fits};
            rem_reg <= fits ? VW'(trial - {1'b0, dvs_reg}) : trial[VW-1:0];
        end
    end

    assign done      = done_reg;
    assign quotient  = dq_reg;
    assign remainder = rem_reg;
endmodule

// ===== hdl/bra_muladd.sv =====
// bit-serial dual multiply-add with saturation, multiplier bits msb first
module bra_muladd #(
    parameter int HW = 49
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [bra_pkg::A_W-1:0]  a,
    input  logic [HW-1:0]            mh,
    input  logic [HW-1:0]            ah,
    input  logic [bra_pkg::DEN_W-1:0] mk,
    input  logic [bra_pkg::DEN_W-1:0] ak,
    output logic                     done,
    output logic [HW-1:0]            h_res,
    output logic                     h_sat,
    output logic [bra_pkg::DEN_W-1:0] k_res,
    output logic                     k_sat
);
    localparam int CW = $clog2(bra_pkg::A_W + 1);
    localparam int KW = bra_pkg::DEN_W;

    logic                    busy_reg;
    logic                    done_reg;
    logic [CW-1:0]           cnt_reg;
    logic [bra_pkg::A_W-1:0] a_reg;
    logic [HW-1:0]           h_reg;
    logic                    hs_reg;
    logic [KW-1:0]           k_reg;
    logic                    ks_reg;
    logic                    bit_now;
    logic                    last_step;
    logic [HW+1:0]           h_sum;
    logic [KW+1:0]           k_sum;

    // one shift-add step on both lanes, addend folded into the last step
    always_comb
    begin
        bit_now   = a_reg[bra_pkg::A_W-1];
        last_step = (cnt_reg == CW'(1));
        h_sum = {1'b0, h_reg, 1'b0} + (bit_now ? (HW+2)'(mh) : '0)
              + (last_step ? (HW+2)'(ah) : '0);
        k_sum = {1'b0, k_reg, 1'b0} + (bit_now ? (KW+2)'(mk) : '0)
              + (last_step ? (KW+2)'(ak) : '0);
    end

    // step control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(bra_pkg::A_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (last_step)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // accumulators with sticky saturation
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg  <= a;
            h_reg  <= '0;
            hs_reg <= 1'b0;
            k_reg  <= '0;
            ks_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            a_reg  <= {a_reg[bra_pkg::A_W-2:0], 1'b0};
            h_reg  <= h_sum[HW-1:0];
            hs_reg <= hs_reg || (h_sum[HW+1:HW] != 2'b00);
            k_reg  <= k_sum[KW-1:0];
            ks_reg <= ks_reg || (k_sum[KW+1:KW] != 2'b00);
        end
    end

    assign done  = done_reg;
    assign h_res = h_reg;
    assign h_sat = hs_reg;
    assign k_res = k_reg;
    assign k_sat = ks_reg;
endmodule
